// ===== sv/tilm_pkg.sv =====
// tilm_pkg: shared types, opcodes and sizes for the task / irq latency monitor
// no dependencies; compiled before every other file of the block
`default_nettype none

package tilm_pkg;

    // default number of trace-point slots, and the width that holds the slot limit
    localparam int unsigned POINTS_DEF  = 16;
    localparam int unsigned POINTS_MAX  = 256;
    localparam int unsigned SLOT_LIM_W  = $clog2(POINTS_MAX) + 1;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned ID_W    = 8;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned CNT_W   = 32;

    // event opcodes; the remaining codes change nothing
    localparam logic [OP_W-1:0] OP_SWITCH    = 3'd0;
    localparam logic [OP_W-1:0] OP_IRQ_ENTER = 3'd1;
    localparam logic [OP_W-1:0] OP_IRQ_LEAVE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLR_MAX   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLR_POINT = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [STAMP_W-1:0] cycle_stamp;
        logic [STAMP_W-1:0] os_time;
        logic [ID_W-1:0]    next_thread;
        logic [ID_W-1:0]    irq_source;
        logic [SLOT_W-1:0]  point_index;
    } t_event;

    typedef struct packed {
        logic [STAMP_W-1:0] task_cycles;
        logic [STAMP_W-1:0] task_os;
        logic [ID_W-1:0]    task_thread;
        logic [STAMP_W-1:0] task_start;
        logic [STAMP_W-1:0] irq_cycles;
        logic [STAMP_W-1:0] irq_os;
        logic [ID_W-1:0]    irq_source;
        logic [STAMP_W-1:0] irq_start;
    } t_stats;

    typedef struct packed {
        logic [CNT_W-1:0] switches;
        logic [CNT_W-1:0] irqs;
    } t_counts;

endpackage

`default_nettype wire

// ===== sv/tilm_if.sv =====
// tilm_evt_if / tilm_res_if: valid-ready channels for trace events and statistics
// depends on tilm_pkg for field widths
`default_nettype none

interface tilm_evt_if;
    import tilm_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [STAMP_W-1:0] cycle_stamp;
    logic [STAMP_W-1:0] os_time;
    logic [ID_W-1:0]    next_thread;
    logic [ID_W-1:0]    irq_source;
    logic [SLOT_W-1:0]  point_index;

    modport source (
        output valid, opcode, cycle_stamp, os_time, next_thread, irq_source, point_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, cycle_stamp, os_time, next_thread, irq_source, point_index,
        output ready
    );
endinterface

interface tilm_res_if;
    import tilm_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] longest_task_cycles;
    logic [STAMP_W-1:0] longest_task_ostime;
    logic [ID_W-1:0]    longest_task_thread;
    logic [STAMP_W-1:0] longest_task_start;
    logic [STAMP_W-1:0] longest_irq_cycles;
    logic [STAMP_W-1:0] longest_irq_ostime;
    logic [ID_W-1:0]    longest_irq_source;
    logic [STAMP_W-1:0] longest_irq_start;
    logic [CNT_W-1:0]   point_switches;
    logic [CNT_W-1:0]   point_irqs;

    modport source (
        output valid, longest_task_cycles, longest_task_ostime, longest_task_thread,
               longest_task_start, longest_irq_cycles, longest_irq_ostime,
               longest_irq_source, longest_irq_start, point_switches, point_irqs,
        input  ready
    );
    modport sink (
        input  valid, longest_task_cycles, longest_task_ostime, longest_task_thread,
               longest_task_start, longest_irq_cycles, longest_irq_ostime,
               longest_irq_source, longest_irq_start, point_switches, point_irqs,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/task_irq_latency_monitor.sv =====
// task_irq_latency_monitor: top level of the task / irq latency monitor
// depends on tilm_pkg, tilm_if, tilm_ram and tilm_core
//
//  channel   dir  handshake        payload
//  i_evt     in   valid / ready    opcode, cycle_stamp, os_time, next_thread,
//                                  irq_source, point_index
//  o_res     out  valid / ready    longest task and irq stats, slot counters
//  i_cfg_*   in   write enable     counting_enable (1 bit)
//
// one beat per cycle sustained while o_res.ready stays high; each event beat passes the
// input register, then the result register, in step with the counter ram's registered read
// reset is synchronous; all timing state, maxima and slot counters read as zero after
// it (slot counters through per-slot valid bits, no clearing pass)
// a stalled result holds in the result register while one more event waits in the
// input register; i_evt.ready drops only when both are full and o_res.ready is low
`default_nettype none

module task_irq_latency_monitor #(
    parameter int unsigned POINTS = tilm_pkg::POINTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    tilm_evt_if.sink         i_evt,
    tilm_res_if.source       o_res
);
    import tilm_pkg::*;

    localparam int unsigned AW    = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int unsigned DEPTH = 1 << AW;
    localparam logic [SLOT_LIM_W-1:0] SLOT_LIM = SLOT_LIM_W'(POINTS);

    // configuration
    logic r_cnt_en;

    // pipeline control
    logic   w_acc;
    logic   w_adv;
    logic   w_out_free;
    logic   r_in_vld;
    logic   r_out_vld;
    t_event w_evt;
    t_event r_in;

    // slot counters
    logic [DEPTH-1:0] r_ent_vld;
    logic             r_byp;
    t_counts          r_byp_data;
    t_counts          w_ram_q;
    t_counts          w_cnt_cur;
    t_counts          n_cnt;
    logic             w_slot_ok;
    logic             w_wr;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    logic             w_fwd;

    // statistics
    t_stats  w_stats;
    t_stats  r_out_stats;
    t_counts r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_cnt_en <= i_cfg_wdata;
        end
    end

    // input register moves on whenever the result register is free or being drained
    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_adv       = r_in_vld && w_out_free;
    assign i_evt.ready = !r_in_vld || w_out_free;
    assign w_acc       = i_evt.valid && i_evt.ready;

    assign w_evt = {
        i_evt.opcode,
        i_evt.cycle_stamp,
        i_evt.os_time,
        i_evt.next_thread,
        i_evt.irq_source,
        i_evt.point_index
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in <= w_evt;
        end
    end

    // counter ram: read when the beat is taken, written when it leaves the input register
    assign w_raddr = AW'(i_evt.point_index);
    assign w_waddr = AW'(r_in.point_index);

    tilm_ram #(
        .WIDTH ($bits(t_counts)),
        .DEPTH (POINTS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_waddr),
        .i_wdata (n_cnt),
        .i_re    (w_acc),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    assign w_slot_ok = {{(SLOT_LIM_W - SLOT_W){1'b0}}, r_in.point_index} < SLOT_LIM;
    assign w_cnt_cur = r_byp ? r_byp_data : w_ram_q;

    always_comb begin
        n_cnt = w_cnt_cur;
        w_wr  = 1'b0;
        unique case (r_in.opcode)
            OP_SWITCH: begin
                if (r_cnt_en && w_slot_ok) begin
                    n_cnt.switches = w_cnt_cur.switches + CNT_W'(1);
                    w_wr           = w_adv;
                end
            end
            OP_IRQ_ENTER: begin
                if (r_cnt_en && w_slot_ok) begin
                    n_cnt.irqs = w_cnt_cur.irqs + CNT_W'(1);
                    w_wr       = w_adv;
                end
            end
            OP_CLR_POINT: begin
                if (w_slot_ok) begin
                    n_cnt = '0;
                    w_wr  = w_adv;
                end
            end
            default: begin
            end
        endcase
    end

    // a write to the slot being read in the same cycle is forwarded;
    // a slot never written since reset reads as zero
    assign w_fwd = w_wr && (w_waddr == w_raddr);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_byp      <= w_fwd || !r_ent_vld[w_raddr];
            r_byp_data <= w_fwd ? n_cnt : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (w_wr) begin
            r_ent_vld[w_waddr] <= 1'b1;
        end
    end

    tilm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_evt   (r_in),
        .o_stats (w_stats)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_stats <= w_stats;
            r_out_cnt   <= w_slot_ok ? n_cnt : '0;
        end
    end

    assign o_res.valid               = r_out_vld;
    assign o_res.longest_task_cycles = r_out_stats.task_cycles;
    assign o_res.longest_task_ostime = r_out_stats.task_os;
    assign o_res.longest_task_thread = r_out_stats.task_thread;
    assign o_res.longest_task_start  = r_out_stats.task_start;
    assign o_res.longest_irq_cycles  = r_out_stats.irq_cycles;
    assign o_res.longest_irq_ostime  = r_out_stats.irq_os;
    assign o_res.longest_irq_source  = r_out_stats.irq_source;
    assign o_res.longest_irq_start   = r_out_stats.irq_start;
    assign o_res.point_switches      = r_out_cnt.switches;
    assign o_res.point_irqs          = r_out_cnt.irqs;
endmodule

`default_nettype wire

// ===== sv/tilm_ram.sv =====
// tilm_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tilm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== sv/tilm_core.sv =====
// tilm_core: switch / irq timing state and longest-interval maxima
// depends on tilm_pkg; updates once per event leaving the input register
`default_nettype none

module tilm_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  tilm_pkg::t_event i_evt,
    output tilm_pkg::t_stats o_stats
);
    import tilm_pkg::*;

    logic [STAMP_W-1:0] r_prev_os, n_prev_os;
    logic [STAMP_W-1:0] r_prev_cyc, n_prev_cyc;
    logic [ID_W-1:0]    r_prev_thread, n_prev_thread;
    logic [STAMP_W-1:0] r_irq_os, n_irq_os;
    logic [STAMP_W-1:0] r_irq_cyc, n_irq_cyc;
    t_stats             r_max, n_max;

    logic [STAMP_W-1:0] w_task_span;
    logic [STAMP_W-1:0] w_irq_span;

    // wrapping 32-bit spans
    assign w_task_span = i_evt.cycle_stamp - r_prev_cyc;
    assign w_irq_span  = i_evt.cycle_stamp - r_irq_cyc;

    always_comb begin
        n_prev_os     = r_prev_os;
        n_prev_cyc    = r_prev_cyc;
        n_prev_thread = r_prev_thread;
        n_irq_os      = r_irq_os;
        n_irq_cyc     = r_irq_cyc;
        n_max         = r_max;
        unique case (i_evt.opcode)
            OP_SWITCH: begin
                // first switch after start has no previous os time
                if (r_prev_os != '0 && w_task_span > r_max.task_cycles) begin
                    n_max.task_cycles = w_task_span;
                    n_max.task_os     = i_evt.os_time - r_prev_os;
                    n_max.task_thread = r_prev_thread;
                    n_max.task_start  = r_prev_cyc;
                end
                n_prev_os     = i_evt.os_time;
                n_prev_cyc    = i_evt.cycle_stamp;
                n_prev_thread = i_evt.next_thread;
            end
            OP_IRQ_ENTER: begin
                n_irq_os  = i_evt.os_time;
                n_irq_cyc = i_evt.cycle_stamp;
            end
            OP_IRQ_LEAVE: begin
                if (w_irq_span > r_max.irq_cycles) begin
                    n_max.irq_cycles = w_irq_span;
                    n_max.irq_os     = i_evt.os_time - r_irq_os;
                    n_max.irq_source = i_evt.irq_source;
                    n_max.irq_start  = r_irq_cyc;
                end
            end
            OP_CLR_MAX: begin
                // ids and task start are kept
                n_max.irq_cycles  = '0;
                n_max.irq_os      = '0;
                n_max.irq_start   = '0;
                n_max.task_cycles = '0;
                n_max.task_os     = '0;
                n_prev_cyc        = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_os     <= '0;
            r_prev_cyc    <= '0;
            r_prev_thread <= '0;
            r_irq_os      <= '0;
            r_irq_cyc     <= '0;
            r_max         <= '0;
        end else if (i_adv) begin
            r_prev_os     <= n_prev_os;
            r_prev_cyc    <= n_prev_cyc;
            r_prev_thread <= n_prev_thread;
            r_irq_os      <= n_irq_os;
            r_irq_cyc     <= n_irq_cyc;
            r_max         <= n_max;
        end
    end

    assign o_stats = n_max;
endmodule

`default_nettype wire

// ===== sv/tilm_checker.sv =====
// tilm_checker: port-level checks on the latency monitor, bound to the top level
// depends on tilm_pkg for field widths; sees only the top level's ports
`default_nettype none

module tilm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [tilm_pkg::STAMP_W-1:0]    i_out_task_cycles,
    input  logic [tilm_pkg::CNT_W-1:0]      i_out_switches
);
    import tilm_pkg::*;

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_task_cycles) && $stable(i_out_switches))
        else $error("result payload changed while stalled");

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one beat of buffering behind a stalled result: then input ready follows output ready
    a_in_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready && i_in_valid && i_in_ready |=>
            (i_in_ready == i_out_ready))
        else $error("input taken without room behind a stalled result");
endmodule

bind task_irq_latency_monitor tilm_checker u_tilm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_evt.valid),
    .i_in_ready        (i_evt.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_out_task_cycles (o_res.longest_task_cycles),
    .i_out_switches    (o_res.point_switches)
);

`default_nettype wire

// ===== sim/tb_task_irq_latency_monitor.sv =====
// tb_task_irq_latency_monitor: self-checking bench for the task / irq latency monitor
// depends on tilm_pkg, tilm_if and the task_irq_latency_monitor rtl
// a directed table and then random trace sequences are checked against a local predictor
`default_nettype none

module tb_task_irq_latency_monitor;
    import tilm_pkg::*;

    // codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int SLOTS     = POINTS_DEF;
    localparam int DIR_ROWS  = 20;
    localparam int HOLD_AT   = 60;   // result beats seen before the long receiver hold-off
    localparam int HOLD_LEN  = 80;   // cycles of that hold-off
    localparam int MAX_SHOWN = 10;

    // one result beat: maxima followed by the addressed slot's counters
    typedef struct packed {
        t_stats  stats;
        t_counts counts;
    } t_stats_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    tilm_evt_if evt_ch ();
    tilm_res_if res_ch ();

    task_irq_latency_monitor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt       (evt_ch),
        .o_res       (res_ch)
    );

    // predictor state, zero like the block after reset
    bit                 count_en;
    bit [STAMP_W-1:0]   last_sw_os;
    bit [STAMP_W-1:0]   last_sw_cyc;
    bit [ID_W-1:0]      last_thr;
    bit [STAMP_W-1:0]   irq_in_os;
    bit [STAMP_W-1:0]   irq_in_cyc;
    t_stats             peak;
    bit [CNT_W-1:0]     sw_cnt  [SLOTS];
    bit [CNT_W-1:0]     irq_cnt [SLOTS];

    t_stats_beat        stats_due_q [$];   // expected beats, oldest first
    int                 mismatches;
    int                 beats_out;
    bit                 full_rate;         // both sides run without idling
    bit [STAMP_W-1:0]   gen_stamp;
    bit [STAMP_W-1:0]   gen_os;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous limit, far above the slowest legal run
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // apply one event to the predicted state and return the beat it should produce
    function automatic t_stats_beat monitor_step(t_event ev);
        bit [STAMP_W-1:0] span;
        bit               slot_ok;
        t_stats_beat      r;
        slot_ok = ev.point_index < SLOTS;
        case (ev.opcode)
            OP_SWITCH: begin
                // no interval while the stored os switch time is still zero
                if (last_sw_os != 0) begin
                    span = ev.cycle_stamp - last_sw_cyc;
                    if (span > peak.task_cycles) begin
                        peak.task_cycles = span;
                        peak.task_os     = ev.os_time - last_sw_os;
                        peak.task_thread = last_thr;
                        peak.task_start  = last_sw_cyc;
                    end
                end
                last_sw_os  = ev.os_time;
                last_sw_cyc = ev.cycle_stamp;
                last_thr    = ev.next_thread;
                if (count_en && slot_ok) sw_cnt[ev.point_index]++;
            end
            OP_IRQ_ENTER: begin
                irq_in_os  = ev.os_time;
                irq_in_cyc = ev.cycle_stamp;
                if (count_en && slot_ok) irq_cnt[ev.point_index]++;
            end
            OP_IRQ_LEAVE: begin
                span = ev.cycle_stamp - irq_in_cyc;
                if (span > peak.irq_cycles) begin
                    peak.irq_cycles = span;
                    peak.irq_os     = ev.os_time - irq_in_os;
                    peak.irq_source = ev.irq_source;
                    peak.irq_start  = irq_in_cyc;
                end
            end
            OP_CLR_MAX: begin
                // thread, source and task start survive the clear
                peak.irq_cycles  = '0;
                peak.irq_os      = '0;
                peak.irq_start   = '0;
                peak.task_cycles = '0;
                peak.task_os     = '0;
                last_sw_cyc      = '0;
            end
            OP_CLR_POINT: begin
                if (slot_ok) begin
                    sw_cnt[ev.point_index]  = '0;
                    irq_cnt[ev.point_index] = '0;
                end
            end
            default: ;
        endcase
        r.stats           = peak;
        r.counts.switches = slot_ok ? sw_cnt[ev.point_index] : '0;
        r.counts.irqs     = slot_ok ? irq_cnt[ev.point_index] : '0;
        return r;
    endfunction

    // mostly zero, sometimes a short gap, rarely a long one; always zero at full rate
    function automatic int pick_gap();
        int r;
        if (full_rate) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) flag_error($sformatf("%s expected %h got %h", name, want, got));
    endtask

    // offer one event beat; valid is left high so a back-to-back beat needs no toggle
    task automatic send_event(input t_event ev, input bit use_gold, input t_stats_beat gold);
        int          gap;
        t_stats_beat calc;
        gap = pick_gap();
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_ch.valid       <= 1'b1;
        evt_ch.opcode      <= ev.opcode;
        evt_ch.cycle_stamp <= ev.cycle_stamp;
        evt_ch.os_time     <= ev.os_time;
        evt_ch.next_thread <= ev.next_thread;
        evt_ch.irq_source  <= ev.irq_source;
        evt_ch.point_index <= ev.point_index;
        @(posedge i_clk);
        while (!evt_ch.ready) @(posedge i_clk);
        calc = monitor_step(ev);
        stats_due_q.push_back(use_gold ? gold : calc);
    endtask

    // stop offering and wait for every predicted beat, then let the pipe settle
    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        while (stats_due_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_counting(input bit v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        count_en    = v;
    endtask

    // well-formed trace traffic on a running clock, with a slice of pure noise
    task automatic make_random(output t_event ev);
        int r;
        if ($urandom_range(0, 9) == 0) gen_stamp += $urandom;
        else gen_stamp += $urandom_range(1, 5000);
        if ($urandom_range(0, 49) == 0) gen_os = '0;
        else gen_os += $urandom_range(0, 3);
        ev.cycle_stamp = gen_stamp;
        ev.os_time     = gen_os;
        ev.next_thread = ID_W'($urandom);
        ev.irq_source  = ID_W'($urandom);
        ev.point_index = SLOT_W'($urandom_range(0, SLOTS - 1));
        r = $urandom_range(0, 99);
        if (r < 38)      ev.opcode = OP_SWITCH;
        else if (r < 58) ev.opcode = OP_IRQ_ENTER;
        else if (r < 78) ev.opcode = OP_IRQ_LEAVE;
        else if (r < 82) ev.opcode = OP_CLR_MAX;
        else if (r < 86) ev.opcode = OP_CLR_POINT;
        else if (r < 90) ev.opcode = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
        else begin
            ev.opcode      = OP_W'($urandom_range(0, 7));
            ev.cycle_stamp = $urandom;
            ev.os_time     = $urandom;
        end
    endtask

    // random phase; no-op codes do not count toward the item total
    task automatic run_random(input int n, input int burst);
        t_event ev;
        int     done;
        done = 0;
        while (done < n) begin
            full_rate = done < burst;
            make_random(ev);
            send_event(ev, 1'b0, '0);
            if (ev.opcode <= OP_CLR_POINT) done++;
        end
        full_rate = 1'b0;
    endtask

    // receiver: random stalls, one long hold-off so the block fills and stalls its input
    initial begin : rx_side
        bit held;
        int n;
        held         = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && beats_out >= HOLD_AT) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if (full_rate) begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // result checker: every accepted beat against the oldest prediction
    always @(posedge i_clk) begin : stats_check
        t_stats_beat want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            beats_out++;
            if (stats_due_q.size() == 0) begin
                flag_error("result beat with nothing expected");
            end else begin
                want = stats_due_q.pop_front();
                check_field("longest_task_cycles", want.stats.task_cycles,
                            res_ch.longest_task_cycles);
                check_field("longest_task_ostime", want.stats.task_os,
                            res_ch.longest_task_ostime);
                check_field("longest_task_thread", 32'(want.stats.task_thread),
                            32'(res_ch.longest_task_thread));
                check_field("longest_task_start", want.stats.task_start,
                            res_ch.longest_task_start);
                check_field("longest_irq_cycles", want.stats.irq_cycles,
                            res_ch.longest_irq_cycles);
                check_field("longest_irq_ostime", want.stats.irq_os,
                            res_ch.longest_irq_ostime);
                check_field("longest_irq_source", 32'(want.stats.irq_source),
                            32'(res_ch.longest_irq_source));
                check_field("longest_irq_start", want.stats.irq_start,
                            res_ch.longest_irq_start);
                check_field("point_switches", want.counts.switches, res_ch.point_switches);
                check_field("point_irqs", want.counts.irqs, res_ch.point_irqs);
            end
        end
    end

    // stimulus
    initial begin : tx_side
        t_event      dir_tab      [DIR_ROWS];
        t_stats_beat dir_gold     [DIR_ROWS];
        bit          dir_has_gold [DIR_ROWS];

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 1'b0;
        evt_ch.valid       = 1'b0;
        evt_ch.opcode      = '0;
        evt_ch.cycle_stamp = '0;
        evt_ch.os_time     = '0;
        evt_ch.next_thread = '0;
        evt_ch.irq_source  = '0;
        evt_ch.point_index = '0;
        full_rate          = 1'b0;
        gen_stamp          = $urandom;
        gen_os             = $urandom_range(1, 1000);

        //                opcode        cycle_stamp    os_time        thread src    slot
        dir_tab[0]  = {OP_RSVD5,     32'h0,         32'h0,         8'h00, 8'h00, 4'd0};
        dir_tab[1]  = {OP_SWITCH,    32'd100,       32'd3,         8'h11, 8'h00, 4'd1};
        dir_tab[2]  = {OP_SWITCH,    32'd350,       32'd10,        8'h22, 8'h00, 4'd1};
        // equal span must not replace the maximum
        dir_tab[3]  = {OP_SWITCH,    32'd600,       32'd20,        8'h33, 8'h00, 4'd1};
        // irq spanning the stamp wrap
        dir_tab[4]  = {OP_IRQ_ENTER, 32'hffff_fff0, 32'hffff_ffff, 8'h00, 8'h00, 4'd2};
        dir_tab[5]  = {OP_IRQ_LEAVE, 32'h10,        32'd5,         8'h00, 8'hab, 4'd2};
        // longest possible irq, then a zero-length one
        dir_tab[6]  = {OP_IRQ_ENTER, 32'h0,         32'h0,         8'h00, 8'h00, 4'd15};
        dir_tab[7]  = {OP_IRQ_LEAVE, 32'hffff_ffff, 32'hffff_ffff, 8'h00, 8'hff, 4'd15};
        dir_tab[8]  = {OP_IRQ_LEAVE, 32'h0,         32'h0,         8'h00, 8'h00, 4'd15};
        dir_tab[9]  = {OP_SWITCH,    32'hffff_ffff, 32'hffff_ffff, 8'hff, 8'h00, 4'd15};
        // switch at os time zero makes the next switch skip its interval
        dir_tab[10] = {OP_SWITCH,    32'h0,         32'h0,         8'h00, 8'h00, 4'd0};
        dir_tab[11] = {OP_SWITCH,    32'h8000_0000, 32'h1234,      8'h5a, 8'h00, 4'd0};
        // clearing the maxima also zeroes the last switch stamp
        dir_tab[12] = {OP_CLR_MAX,   32'h0,         32'h0,         8'h00, 8'h00, 4'd1};
        dir_tab[13] = {OP_SWITCH,    32'h8000_0100, 32'h1240,      8'ha5, 8'h00, 4'd1};
        dir_tab[14] = {OP_CLR_POINT, 32'h0,         32'h0,         8'h00, 8'h00, 4'd1};
        dir_tab[15] = {OP_RSVD6,     32'hffff_ffff, 32'hffff_ffff, 8'hff, 8'hff, 4'd2};
        dir_tab[16] = {OP_RSVD7,     32'h1234_5678, 32'h9abc_def0, 8'h3c, 8'hc3, 4'd15};
        dir_tab[17] = {OP_IRQ_ENTER, 32'd1000,      32'd40,        8'h00, 8'h00, 4'd14};
        dir_tab[18] = {OP_IRQ_LEAVE, 32'd1000,      32'd40,        8'h00, 8'h77, 4'd14};
        dir_tab[19] = {OP_CLR_POINT, 32'h0,         32'h0,         8'h00, 8'h00, 4'd15};

        foreach (dir_has_gold[k]) begin
            dir_has_gold[k] = 1'b0;
            dir_gold[k]     = '0;
        end
        // rows whose beat is plain from the table, counting enabled
        dir_has_gold[0] = 1'b1;
        dir_has_gold[1] = 1'b1;
        dir_gold[1]     = {32'd0, 32'd0, 8'h00, 32'd0, 32'd0, 32'd0, 8'h00, 32'd0,
                           32'd1, 32'd0};
        dir_has_gold[2] = 1'b1;
        dir_gold[2]     = {32'd250, 32'd7, 8'h11, 32'd100, 32'd0, 32'd0, 8'h00, 32'd0,
                           32'd2, 32'd0};
        dir_has_gold[5] = 1'b1;
        dir_gold[5]     = {32'd250, 32'd7, 8'h11, 32'd100, 32'h20, 32'd6, 8'hab,
                           32'hffff_fff0, 32'd0, 32'd1};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_counting(1'b1);
        for (int k = 0; k < DIR_ROWS; k++) send_event(dir_tab[k], dir_has_gold[k], dir_gold[k]);

        run_random(300, 0);
        set_counting(1'b0);
        run_random(150, 0);
        set_counting(1'b1);
        run_random(150, 80);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/tilm_pkg.sv
sv/tilm_if.sv
sv/tilm_ram.sv
sv/tilm_core.sv
sv/task_irq_latency_monitor.sv
sv/tilm_checker.sv
sim/tb_task_irq_latency_monitor.sv
